/* rtl/lcb_pkg.sv */
// Shared types, codes and helpers for the LED channel blink controller.
`default_nettype none

package lcb_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CfgW       = 16;
  localparam int NumChan    = 6;
  localparam int NumTimed   = 3;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CfgW-1:0]       cfg_t;

  // input modes
  localparam logic [2:0] ModeNormal   = 3'd0;
  localparam logic [2:0] ModePriCmd   = 3'd1;
  localparam logic [2:0] ModeEnable   = 3'd2;
  localparam logic [2:0] ModePriority = 3'd3;
  localparam logic [2:0] ModeTick     = 3'd4;

  // targets
  localparam logic [2:0] TgtNone  = 3'd0;
  localparam logic [2:0] TgtAll   = 3'd1;
  localparam logic [2:0] TgtRed   = 3'd2;
  localparam logic [2:0] TgtGreen = 3'd3;
  localparam logic [2:0] TgtBlue  = 3'd4;
  localparam logic [2:0] TgtOut1  = 3'd5;
  localparam logic [2:0] TgtOut2  = 3'd6;
  localparam logic [2:0] TgtOut3  = 3'd7;

  // channel operations
  localparam logic [2:0] OpSet      = 3'd0;
  localparam logic [2:0] OpClear    = 3'd1;
  localparam logic [2:0] OpToggle   = 3'd2;
  localparam logic [2:0] OpBlink    = 3'd3;
  localparam logic [2:0] OpBlinking = 3'd4;

  // configuration register indexes
  localparam logic CfgBlinkMs    = 1'b0;
  localparam logic CfgBlinkingMs = 1'b1;

  localparam cfg_t BlinkMsRst    = CfgW'(500);
  localparam cfg_t BlinkingMsRst = CfgW'(300);

  localparam logic [32:0] TimerMaxW = (33'(1) << TIMER_BITS) - 33'(1);

  typedef struct packed {
    logic       cmd_en;
    logic [2:0] op;
    logic       tick_en;
    logic       timed;
  } chan_ctl_t;

  // Period register to timer load: zero loads one, too large saturates.
  function automatic timer_t load_timer(cfg_t v);
    logic [32:0] ext;
    ext = 33'(v);
    if (v == '0) begin
      return timer_t'(1);
    end else if (ext > TimerMaxW) begin
      return '1;
    end else begin
      return timer_t'(v);
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/led_channel_blink_controller.sv */
// Top level: stream ports, config registers, input and result registers.
`default_nettype none

// Takes one word per clock unless stalled and returns exactly one result word per
// input word, via the input register, then the result register once the output side
// is ready. Throughput is one word per cycle while the output side is ready, set by
// the single pass through the channel logic; a stalled result holds while one more
// word is taken into the input register. Each input word is a command, an enable or
// priority flag change, or a millisecond tick; the result carries all six output
// levels after that word and a refused bit. The user must write configuration through
// cfg_we_i/cfg_idx_i/cfg_data_i only while no word is in flight; this is not enforced.
module led_channel_blink_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [15:0]          s_axis_tdata_i,  // mode[2:0], target[5:3], op_code[8:6],
                                                // flag_value[9], zero[15:10]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [7:0]           m_axis_tdata_o,  // led_levels[5:0], status[6], zero[7]
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  lcb_pkg::cfg_t        cfg_data_i
);
  import lcb_pkg::*;

  cfg_t       blink_ms_q, blinking_ms_q;
  logic       in_vld_q, out_vld_q;
  logic [2:0] mode_q, target_q, op_q;
  logic       flag_q;
  logic [6:0] res_q;
  logic [5:0] levels;
  logic       status;
  logic       s_fire, adv;

  assign adv             = in_vld_q & (~out_vld_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_vld_q | adv;
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_ms_q    <= BlinkMsRst;
      blinking_ms_q <= BlinkingMsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBlinkMs:    blink_ms_q    <= cfg_data_i;
        CfgBlinkingMs: blinking_ms_q <= cfg_data_i;
        default:       blink_ms_q    <= blink_ms_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_fire) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      mode_q   <= s_axis_tdata_i[2:0];
      target_q <= s_axis_tdata_i[5:3];
      op_q     <= s_axis_tdata_i[8:6];
      flag_q   <= s_axis_tdata_i[9];
    end
    if (adv) begin
      res_q <= {status, levels};
    end
  end

  lcb_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .mode_i       (mode_q),
    .target_i     (target_q),
    .op_code_i    (op_q),
    .flag_value_i (flag_q),
    .blink_ms_i   (blink_ms_q),
    .blinking_ms_i(blinking_ms_q),
    .led_levels_o (levels),
    .status_o     (status)
  );

endmodule

`default_nettype wire

/* rtl/lcb_chan.sv */
// Next-state logic of one LED channel: command, tick and timer reload.
`default_nettype none

module lcb_chan (
  input  lcb_pkg::chan_ctl_t ctl_i,
  input  logic               level_i,
  input  logic [2:0]         op_i,
  input  lcb_pkg::timer_t    timer_i,
  input  lcb_pkg::timer_t    blink_load_i,
  input  lcb_pkg::timer_t    blinking_load_i,
  output logic               level_o,
  output logic [2:0]         op_o,
  output lcb_pkg::timer_t    timer_o
);
  import lcb_pkg::*;

  timer_t timer_dec;

  assign timer_dec = timer_i - timer_t'(1);

  always_comb begin
    level_o = level_i;
    op_o    = op_i;
    timer_o = timer_i;
    if (ctl_i.cmd_en) begin
      timer_o = '0;
      op_o    = ctl_i.op;
      case (ctl_i.op)
        OpSet: begin
          if (op_i != OpSet) level_o = 1'b1;
        end
        OpClear: begin
          if (op_i != OpClear) level_o = 1'b0;
        end
        OpToggle: begin
          level_o = ~level_i;
        end
        OpBlink: begin
          if (ctl_i.timed) begin
            level_o = 1'b1;
            timer_o = blink_load_i;
          end
        end
        default: begin
          if (ctl_i.timed) begin
            level_o = 1'b1;
            timer_o = blinking_load_i;
          end
        end
      endcase
    end else if (ctl_i.tick_en && ctl_i.timed && timer_i != '0) begin
      timer_o = timer_dec;
      if (timer_dec == '0) begin
        if (op_i == OpBlinking) begin
          level_o = ~level_i;
          timer_o = blinking_load_i;
        end else begin
          level_o = 1'b0;
          op_o    = OpClear;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/lcb_core.sv */
// Item decode, channel fan-out and channel state registers.
`default_nettype none

module lcb_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic [2:0]            mode_i,
  input  logic [2:0]            target_i,
  input  logic [2:0]            op_code_i,
  input  logic                  flag_value_i,
  input  lcb_pkg::cfg_t         blink_ms_i,
  input  lcb_pkg::cfg_t         blinking_ms_i,
  output logic [5:0]            led_levels_o,
  output logic                  status_o
);
  import lcb_pkg::*;

  logic [NumChan-1:0] level_q, level_d;
  logic [2:0]         op_q   [NumChan];
  logic [2:0]         op_d   [NumChan];
  timer_t             timer_q[NumTimed];
  timer_t             timer_d[NumChan];
  chan_ctl_t          ctl    [NumChan];
  logic               en_q, en_d, pri_q, pri_d;
  logic               cmd_go, dis, tick;
  logic [NumChan-1:0] sel;
  timer_t             blink_load, blinking_load;

  assign blink_load    = load_timer(blink_ms_i);
  assign blinking_load = load_timer(blinking_ms_i);

  always_comb begin
    status_o = 1'b0;
    cmd_go   = 1'b0;
    dis      = 1'b0;
    tick     = 1'b0;
    en_d     = en_q;
    pri_d    = pri_q;
    case (mode_i)
      ModeNormal, ModePriCmd: begin
        if (mode_i == ModeNormal && pri_q) begin
          status_o = 1'b1;
        end else if (!en_q && target_i inside {[TgtAll:TgtBlue]}) begin
          status_o = 1'b1;
        end else if (op_code_i > OpBlinking) begin
          status_o = 1'b1;
        end else begin
          cmd_go = 1'b1;
        end
      end
      ModeEnable: begin
        if (en_q != flag_value_i) begin
          dis  = ~flag_value_i;
          en_d = flag_value_i;
        end
      end
      ModePriority: pri_d = flag_value_i;
      ModeTick:     tick  = 1'b1;
      default:      status_o = 1'b1;
    endcase
  end

  always_comb begin
    case (target_i)
      TgtAll:   sel = 6'b000111;
      TgtRed:   sel = 6'b000001;
      TgtGreen: sel = 6'b000010;
      TgtBlue:  sel = 6'b000100;
      TgtOut1:  sel = 6'b001000;
      TgtOut2:  sel = 6'b010000;
      TgtOut3:  sel = 6'b100000;
      default:  sel = 6'b000000;
    endcase
  end

  for (genvar i = 0; i < NumChan; i++) begin : g_chan
    localparam bit Timed = (i < NumTimed);
    timer_t timer_cur;

    if (Timed) begin : g_timed
      assign timer_cur = timer_q[i];
    end else begin : g_plain
      assign timer_cur = '0;
    end

    assign ctl[i].cmd_en  = (cmd_go & sel[i]) | (dis & Timed);
    assign ctl[i].op      = dis ? OpClear : op_code_i;
    assign ctl[i].tick_en = tick;
    assign ctl[i].timed   = Timed;

    lcb_chan u_chan (
      .ctl_i          (ctl[i]),
      .level_i        (level_q[i]),
      .op_i           (op_q[i]),
      .timer_i        (timer_cur),
      .blink_load_i   (blink_load),
      .blinking_load_i(blinking_load),
      .level_o        (level_d[i]),
      .op_o           (op_d[i]),
      .timer_o        (timer_d[i])
    );
  end

  assign led_levels_o = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      en_q    <= 1'b1;
      pri_q   <= 1'b0;
      for (int i = 0; i < NumChan; i++) op_q[i] <= OpClear;
      for (int i = 0; i < NumTimed; i++) timer_q[i] <= '0;
    end else if (adv_i) begin
      level_q <= level_d;
      en_q    <= en_d;
      pri_q   <= pri_d;
      for (int i = 0; i < NumChan; i++) op_q[i] <= op_d[i];
      for (int i = 0; i < NumTimed; i++) timer_q[i] <= timer_d[i];
    end
  end

endmodule

`default_nettype wire

/* rtl/lcb_checker.sv */
// Port-level checks for the LED channel blink controller, bound to the top level.
`default_nettype none

module lcb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word dropped or changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[7])
    else $error("result padding bit set");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid right after reset");

endmodule

bind led_channel_blink_controller lcb_checker u_lcb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

`default_nettype wire

/* tb/sv/tb_led_channel_blink_controller.sv */
// Testbench for the LED channel blink controller: stream stimulus, predicted levels, checks.
module tb_led_channel_blink_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import lcb_pkg::*;

  localparam logic [2:0] ModeUnused = 3'd7;
  localparam logic [2:0] OpUnknown  = 3'd5;
  localparam int         CycleLimit = 200000;
  localparam int         SegItems   = 232;

  typedef struct packed {
    logic       status;
    logic [5:0] levels;
  } blink_result_t;

  class lcb_scoreboard;
    logic [2:0]    last_op [NumChan];
    logic [5:0]    levels;
    timer_t        ticks_left [NumTimed];
    bit            enabled;
    bit            pri_on;
    cfg_t          blink_len;
    cfg_t          blinking_len;
    blink_result_t level_q [$];
    int            n_bad;

    function new();
      for (int i = 0; i < NumChan; i++) last_op[i] = OpClear;
      for (int i = 0; i < NumTimed; i++) ticks_left[i] = '0;
      levels       = '0;
      enabled      = 1'b1;
      pri_on       = 1'b0;
      blink_len    = BlinkMsRst;
      blinking_len = BlinkingMsRst;
      n_bad        = 0;
    endfunction

    function void set_reg(logic idx, cfg_t v);
      if (idx == CfgBlinkMs) blink_len = v;
      else blinking_len = v;
    endfunction

    // timer is as wide as the register, so only zero needs fixing up
    function timer_t period_load(cfg_t v);
      return (v == '0) ? timer_t'(1) : timer_t'(v);
    endfunction

    function void chan_cmd(int ch, logic [2:0] op);
      bit timed;
      timed = ch < NumTimed;
      if (timed) ticks_left[ch] = '0;
      case (op)
        OpSet:    if (last_op[ch] != OpSet) levels[ch] = 1'b1;
        OpClear:  if (last_op[ch] != OpClear) levels[ch] = 1'b0;
        OpToggle: levels[ch] = ~levels[ch];
        OpBlink: begin
          if (timed) begin
            levels[ch]     = 1'b1;
            ticks_left[ch] = period_load(blink_len);
          end
        end
        default: begin
          if (timed) begin
            levels[ch]     = 1'b1;
            ticks_left[ch] = period_load(blinking_len);
          end
        end
      endcase
      last_op[ch] = op;
    endfunction

    function logic run_cmd(logic [2:0] target, logic [2:0] op);
      if (!enabled && target >= TgtAll && target <= TgtBlue) return 1'b1;
      if (op > OpBlinking) return 1'b1;
      case (target)
        TgtNone: ;
        TgtAll: begin
          chan_cmd(0, op);
          chan_cmd(2, op);
          chan_cmd(1, op);
        end
        TgtRed:   chan_cmd(0, op);
        TgtGreen: chan_cmd(1, op);
        TgtBlue:  chan_cmd(2, op);
        default:  chan_cmd(NumTimed + int'(target - TgtOut1), op);
      endcase
      return 1'b0;
    endfunction

    function void ms_tick();
      for (int ch = 0; ch < NumTimed; ch++) begin
        if (ticks_left[ch] != '0) begin
          ticks_left[ch] = ticks_left[ch] - timer_t'(1);
          if (ticks_left[ch] == '0) begin
            if (last_op[ch] == OpBlinking) begin
              levels[ch]     = ~levels[ch];
              ticks_left[ch] = period_load(blinking_len);
            end else begin
              levels[ch]  = 1'b0;
              last_op[ch] = OpClear;
            end
          end
        end
      end
    endfunction

    function void note_word(logic [15:0] w);
      logic [2:0]    mode;
      logic [2:0]    target;
      logic [2:0]    op;
      logic          flag;
      blink_result_t r;
      mode     = w[2:0];
      target   = w[5:3];
      op       = w[8:6];
      flag     = w[9];
      r.status = 1'b0;
      case (mode)
        ModeNormal: r.status = pri_on ? 1'b1 : run_cmd(target, op);
        ModePriCmd: r.status = run_cmd(target, op);
        ModeEnable: begin
          if (enabled != flag) begin
            if (!flag) begin
              chan_cmd(0, OpClear);
              chan_cmd(2, OpClear);
              chan_cmd(1, OpClear);
            end
            enabled = flag;
          end
        end
        ModePriority: pri_on = flag;
        ModeTick:     ms_tick();
        default:      r.status = 1'b1;
      endcase
      r.levels = levels;
      level_q.push_back(r);
    endfunction

    function void flag_bad(string msg);
      n_bad++;
      if (n_bad <= 10) $display("%s", msg);
    endfunction

    function void check_word(logic [7:0] d);
      blink_result_t e;
      if (level_q.size() == 0) begin
        flag_bad($sformatf("unexpected result word %h", d));
        return;
      end
      e = level_q.pop_front();
      if (d[5:0] !== e.levels)
        flag_bad($sformatf("led_levels: expected %b, got %b", e.levels, d[5:0]));
      if (d[6] !== e.status)
        flag_bad($sformatf("status: expected %b, got %b", e.status, d[6]));
      if (d[7] !== 1'b0)
        flag_bad($sformatf("pad bit: expected 0, got %b", d[7]));
    endfunction

    function int pending();
      return level_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_valid;
  logic        s_axis_tready_o;
  logic [15:0] s_data;
  logic        m_axis_tvalid_o;
  logic        m_ready;
  logic [7:0]  m_axis_tdata_o;
  logic        cfg_we;
  logic        cfg_idx;
  cfg_t        cfg_data;

  int            idle_pct;
  int            stall_pct;
  lcb_scoreboard sb;

  cfg_t blink_tab    [8] = '{16'd3, 16'd1, 16'd0, 16'd6, 16'd2, 16'd65535, 16'd4, 16'd10};
  cfg_t blinking_tab [8] = '{16'd2, 16'd1, 16'd4, 16'd0, 16'd7, 16'd3, 16'd65535, 16'd5};

  led_channel_blink_controller i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) sb.note_word(s_data);
      if (m_axis_tvalid_o && m_ready) sb.check_word(m_axis_tdata_o);
    end
  end

  initial begin
    m_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  function automatic logic [15:0] pack_cmd(logic [2:0] mode, logic [2:0] target,
                                           logic [2:0] op, logic flag);
    return {6'b0, flag, op, target, mode};
  endfunction

  function automatic logic [15:0] rand_word();
    int         r;
    logic [2:0] mode;
    logic [2:0] op;
    logic       flag;
    r    = $urandom_range(99);
    op   = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    flag = 1'($urandom_range(1));
    if (r < 35) mode = ModeTick;
    else if (r < 63) mode = ModeNormal;
    else if (r < 78) mode = ModePriCmd;
    else if (r < 85) begin
      mode = ModeEnable;
      flag = ($urandom_range(9) >= 3);
    end else if (r < 92) begin
      mode = ModePriority;
      flag = ($urandom_range(9) < 3);
    end else if (r < 95) mode = 3'($urandom_range(7, 5));
    else return {6'b0, 10'($urandom_range(1023))};
    return pack_cmd(mode, 3'($urandom_range(7)), op, flag);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_word(logic [15:0] w);
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= w;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic drive(logic [2:0] mode, logic [2:0] target, logic [2:0] op, logic flag);
    send_word(pack_cmd(mode, target, op, flag));
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, cfg_t v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    s_valid   = 1'b0;
    s_data    = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CfgBlinkMs;
    cfg_data  = '0;
    rst_ni    = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    sb        = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: repeated set/clear, plain outputs, blink at reset periods
    drive(ModeNormal, TgtRed, OpSet, 1'b0);
    drive(ModeNormal, TgtRed, OpSet, 1'b0);
    drive(ModeNormal, TgtGreen, OpClear, 1'b0);
    drive(ModeNormal, TgtOut1, OpToggle, 1'b1);
    drive(ModeNormal, TgtOut2, OpBlink, 1'b0);
    drive(ModeNormal, TgtOut3, OpBlinking, 1'b1);
    drive(ModeNormal, TgtBlue, OpBlink, 1'b0);
    drive(ModeTick, TgtNone, OpSet, 1'b0);
    wait_idle();
    write_reg(CfgBlinkMs, 16'd2);
    write_reg(CfgBlinkingMs, 16'd2);
    drive(ModeNormal, TgtAll, OpBlinking, 1'b0);
    repeat (3) drive(ModeTick, TgtNone, OpSet, 1'b0);
    drive(ModeNormal, TgtRed, OpBlink, 1'b0);
    repeat (2) drive(ModeTick, TgtNone, OpSet, 1'b0);
    drive(ModeNormal, TgtNone, OpSet, 1'b0);
    drive(ModeNormal, TgtGreen, OpUnknown, 1'b0);
    drive(ModeUnused, TgtRed, OpSet, 1'b1);
    // priority mode refuses normal commands only
    drive(ModePriority, TgtNone, OpSet, 1'b1);
    drive(ModeNormal, TgtRed, OpToggle, 1'b0);
    drive(ModePriCmd, TgtRed, OpToggle, 1'b0);
    drive(ModePriority, TgtNone, OpSet, 1'b0);
    // disable clears colors and refuses color targets
    drive(ModeEnable, TgtNone, OpSet, 1'b0);
    drive(ModeNormal, TgtAll, OpSet, 1'b0);
    drive(ModeNormal, TgtOut1, OpSet, 1'b0);
    drive(ModeEnable, TgtNone, OpSet, 1'b0);
    drive(ModeEnable, TgtNone, OpSet, 1'b1);
    drive(ModeEnable, TgtNone, OpSet, 1'b1);

    for (int seg = 0; seg < 8; seg++) begin
      wait_idle();
      write_reg(CfgBlinkMs, blink_tab[seg]);
      write_reg(CfgBlinkingMs, blinking_tab[seg]);
      case (seg / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      for (int n = 0; n < SegItems; n++) send_word(rand_word());
    end

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (sb.n_bad == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
